### rtl/core/jsu_pkg.sv
// jsu_pkg: shared types and constants for the json string unescape core
// holds the phase encoding, error codes and the result bundle type
// depends on nothing
`timescale 1ns / 1ps

package jsu_pkg;

	// decoder phase, one-hot
	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_STR     = 7'b0000010,
		PH_ESC     = 7'b0000100,
		PH_HEX1    = 7'b0001000,
		PH_SURR_BS = 7'b0010000,
		PH_SURR_U  = 7'b0100000,
		PH_HEX2    = 7'b1000000
	} phase_t;

	// error codes as seen on error_code
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_MISS_QUOTE = 3'd1,
		ERR_BAD_ESC    = 3'd2,
		ERR_CTRL_CHAR  = 3'd3,
		ERR_BAD_HEX    = 3'd4,
		ERR_BAD_SURR   = 3'd5,
		ERR_NO_OPEN    = 3'd6
	} err_code_t;

	// characters the decoder looks for
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

	// surrogate ranges
	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;

	// all words produced by one input byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            str_end;
		err_code_t       err;
	} result_t;

endpackage

### rtl/core/jsu_decode.sv
// jsu_decode: parser state and single-pass decode of one input byte
// produces the whole result bundle (up to four words) for the byte
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       in_byte,
	output jsu_pkg::result_t res,
	output logic             res_valid
);
	import jsu_pkg::*;

	phase_t      phase_q;
	logic [1:0]  hex_cnt_q;
	logic [15:0] code_unit_q;
	logic [15:0] high_surr_q;

	phase_t      phase_d;
	logic [1:0]  hex_cnt_d;
	logic [15:0] code_unit_d;
	logic [15:0] high_surr_d;

	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] unit_shift;
	logic        group_done;
	logic [20:0] pair_cp;

	// single-word result helper
	function automatic result_t one_word(logic [7:0] b, logic e, err_code_t err);
		result_t r;
		r = '0;
		r.bytes[0] = b;
		r.last_idx = 2'd0;
		r.str_end = e;
		r.err = err;
		return r;
	endfunction

	// utf-8 encoding of a code point
	function automatic result_t utf8(logic [20:0] u);
		result_t r;
		r = '0;
		r.err = ERR_NONE;
		if (u <= 21'h7F) begin
			r.bytes[0] = u[7:0];
			r.last_idx = 2'd0;
		end else if (u <= 21'h7FF) begin
			r.bytes[0] = {3'b110, u[10:6]};
			r.bytes[1] = {2'b10, u[5:0]};
			r.last_idx = 2'd1;
		end else if (u <= 21'hFFFF) begin
			r.bytes[0] = {4'b1110, u[15:12]};
			r.bytes[1] = {2'b10, u[11:6]};
			r.bytes[2] = {2'b10, u[5:0]};
			r.last_idx = 2'd2;
		end else begin
			r.bytes[0] = {5'b11110, u[20:18]};
			r.bytes[1] = {2'b10, u[17:12]};
			r.bytes[2] = {2'b10, u[11:6]};
			r.bytes[3] = {2'b10, u[5:0]};
			r.last_idx = 2'd3;
		end
		return r;
	endfunction

	// hex digit value
	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign unit_shift = {code_unit_q[11:0], hex_val};
	assign group_done = (hex_cnt_q == 2'd3);
	assign pair_cp = {1'b0, high_surr_q[9:0], unit_shift[9:0]} + 21'h10000;

	// next state and result bundle
	always_comb begin
		phase_d = phase_q;
		hex_cnt_d = hex_cnt_q;
		code_unit_d = code_unit_q;
		high_surr_d = high_surr_q;
		res = one_word(8'h00, 1'b0, ERR_NONE);
		res_valid = 1'b0;
		unique case (phase_q)
			PH_STR: begin
				if (in_byte == CH_QUOTE) begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b1, ERR_NONE);
					res_valid = 1'b1;
				end else if (in_byte == 8'h00) begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_MISS_QUOTE);
					res_valid = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else if (in_byte < CH_CTRL_LIMIT) begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_CTRL_CHAR);
					res_valid = 1'b1;
				end else begin
					res = one_word(in_byte, 1'b0, ERR_NONE);
					res_valid = 1'b1;
				end
			end
			PH_ESC: begin
				res_valid = 1'b1;
				phase_d = PH_STR;
				unique case (in_byte)
					8'h6E: res = one_word(8'h0A, 1'b0, ERR_NONE);
					8'h72: res = one_word(8'h0D, 1'b0, ERR_NONE);
					8'h62: res = one_word(8'h08, 1'b0, ERR_NONE);
					8'h66: res = one_word(8'h0C, 1'b0, ERR_NONE);
					8'h74: res = one_word(8'h09, 1'b0, ERR_NONE);
					CH_BSLASH: res = one_word(CH_BSLASH, 1'b0, ERR_NONE);
					CH_SLASH: res = one_word(CH_SLASH, 1'b0, ERR_NONE);
					CH_QUOTE: res = one_word(CH_QUOTE, 1'b0, ERR_NONE);
					CH_U: begin
						res_valid = 1'b0;
						phase_d = PH_HEX1;
						hex_cnt_d = 2'd0;
						code_unit_d = 16'h0000;
					end
					default: begin
						phase_d = PH_IDLE;
						res = one_word(8'h00, 1'b0, ERR_BAD_ESC);
					end
				endcase
			end
			PH_HEX1: begin
				if (!hex_ok) begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_BAD_HEX);
					res_valid = 1'b1;
				end else if (!group_done) begin
					code_unit_d = unit_shift;
					hex_cnt_d = hex_cnt_q + 2'd1;
				end else if (unit_shift >= HI_SURR_MIN && unit_shift <= HI_SURR_MAX) begin
					high_surr_d = unit_shift;
					code_unit_d = 16'h0000;
					hex_cnt_d = 2'd0;
					phase_d = PH_SURR_BS;
				end else begin
					code_unit_d = 16'h0000;
					hex_cnt_d = 2'd0;
					phase_d = PH_STR;
					res = utf8({5'd0, unit_shift});
					res_valid = 1'b1;
				end
			end
			PH_SURR_BS: begin
				if (in_byte == CH_BSLASH) begin
					phase_d = PH_SURR_U;
				end else begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_BAD_SURR);
					res_valid = 1'b1;
				end
			end
			PH_SURR_U: begin
				if (in_byte == CH_U) begin
					phase_d = PH_HEX2;
					hex_cnt_d = 2'd0;
					code_unit_d = 16'h0000;
				end else begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_BAD_SURR);
					res_valid = 1'b1;
				end
			end
			PH_HEX2: begin
				if (!hex_ok) begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_BAD_HEX);
					res_valid = 1'b1;
				end else if (!group_done) begin
					code_unit_d = unit_shift;
					hex_cnt_d = hex_cnt_q + 2'd1;
				end else if (unit_shift < LO_SURR_MIN || unit_shift > LO_SURR_MAX) begin
					phase_d = PH_IDLE;
					res = one_word(8'h00, 1'b0, ERR_BAD_SURR);
					res_valid = 1'b1;
				end else begin
					code_unit_d = 16'h0000;
					high_surr_d = 16'h0000;
					hex_cnt_d = 2'd0;
					phase_d = PH_STR;
					res = utf8(pair_cp);
					res_valid = 1'b1;
				end
			end
			PH_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					phase_d = PH_STR;
				end else begin
					res = one_word(8'h00, 1'b0, ERR_NO_OPEN);
					res_valid = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		// every return to idle clears the escape state
		if (phase_d == PH_IDLE) begin
			hex_cnt_d = 2'd0;
			code_unit_d = 16'h0000;
			high_surr_d = 16'h0000;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_cnt_q <= 2'd0;
			code_unit_q <= 16'h0000;
			high_surr_q <= 16'h0000;
		end else if (take) begin
			phase_q <= phase_d;
			hex_cnt_q <= hex_cnt_d;
			code_unit_q <= code_unit_d;
			high_surr_q <= high_surr_d;
		end
	end

endmodule

### rtl/core/jsu_outbuf.sv
// jsu_outbuf: result register holding one byte's bundle of words
// drains one word per accepted output cycle
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             free,
	output logic [7:0]       out_byte,
	output logic             string_end,
	output logic [2:0]       error_code,
	output logic             last
);
	import jsu_pkg::*;

	result_t    res_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       take_last;

	// word select
	assign out_valid = valid_q;
	assign out_byte = res_q.bytes[idx_q];
	assign string_end = res_q.str_end;
	assign error_code = res_q.err;
	assign last = (idx_q == res_q.last_idx);

	// buffer frees up when its final word leaves
	assign take_last = valid_q && !out_stall && last;
	assign free = !valid_q || take_last;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (take_last) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (valid_q && !out_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### rtl/core/json_string_unescape_utf8_core.sv
// json_string_unescape_utf8_core: top level of the json string unescaper
// ties the byte decoder to the result register
// depends on jsu_pkg, jsu_decode, jsu_outbuf
//
//   channel | dir | handshake                   | payload
//   in      | in  | in_valid / in_stall         | in_byte
//   out     | out | out_valid / out_stall       | out_byte, string_end, error_code, last
//
// one input byte per cycle while in_stall is low; its first word appears in the cycle
// after acceptance; a byte that decodes to n words (n up to 4) holds the input until
// its final word leaves, as the result register drains one word per cycle unless stalled
// bytes giving no word (opening quote, backslash, u, hex digits short of a full character) pass without a bubble
// reset is asynchronous and brings the parser to idle awaiting the opening quote
// in_stall is high while the result register holds a word that does not leave this
// cycle as the final one, so out_stall reaches in_stall in the same cycle
`timescale 1ns / 1ps

module json_string_unescape_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       string_end,
	output logic [2:0] error_code,
	output logic       last
);
	import jsu_pkg::*;

	result_t res;
	logic    res_valid;
	logic    free;
	logic    take;

	// input handshake
	assign in_stall = !free;
	assign take = in_valid && free;

	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.res       (res),
		.res_valid (res_valid)
	);

	jsu_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take && res_valid),
		.res        (res),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.free       (free),
		.out_byte   (out_byte),
		.string_end (string_end),
		.error_code (error_code),
		.last       (last)
	);

endmodule

### rtl/core/json_string_unescape_utf8_core_chk.sv
// json_string_unescape_utf8_core_chk: port-level checks for the unescaper
// bound to the top level; sees only its ports
// depends on jsu_pkg and json_string_unescape_utf8_core
`timescale 1ns / 1ps

module json_string_unescape_utf8_core_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       string_end,
	input logic [2:0] error_code,
	input logic       last
);
	import jsu_pkg::*;

	// a stalled word holds
	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("stalled output word changed");

	// a multi-word sequence continues after a non-final word
	property p_seq_cont;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid;
	endproperty
	a_seq_cont: assert property (p_seq_cont) else $error("word sequence broken off");

	// input only backs up behind pending words
	property p_stall_cause;
		@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall;
	endproperty
	a_stall_cause: assert property (p_stall_cause) else $error("input stalled with no word");

	// end and error words are single, zero-byte words
	property p_term_word;
		@(posedge clk) disable iff (!arst_n)
		out_valid && (string_end || error_code != ERR_NONE) |->
			last && out_byte == 8'h00 && !(string_end && error_code != ERR_NONE);
	endproperty
	a_term_word: assert property (p_term_word) else $error("malformed end or error word");

endmodule

bind json_string_unescape_utf8_core json_string_unescape_utf8_core_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.string_end (string_end),
	.error_code (error_code),
	.last       (last)
);
